// ===== sv/tkct_pkg.sv =====
// ----------------------------------------------------------------------------
// tkct_pkg
// Types, codes and decode functions for the terminal key and cursor tracker.
// ----------------------------------------------------------------------------
package tkct_pkg;

  localparam int COORD_BITS = 10;
  localparam int SIZE_BITS  = 10;
  localparam int CLASS_BITS = 4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CLASS_BITS-1:0] key_class_t;

  localparam key_class_t KEY_PLAIN = 4'd0;
  localparam key_class_t KEY_LEFT  = 4'd1;
  localparam key_class_t KEY_RIGHT = 4'd2;
  localparam key_class_t KEY_UP    = 4'd3;
  localparam key_class_t KEY_DOWN  = 4'd4;
  localparam key_class_t KEY_HOME  = 4'd5;
  localparam key_class_t KEY_END   = 4'd6;
  localparam key_class_t KEY_PGUP  = 4'd7;
  localparam key_class_t KEY_PGDN  = 4'd8;
  localparam key_class_t KEY_DEL   = 4'd9;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_CTRL_Q  = 8'h11;
  localparam logic [7:0] CH_BRACKET = 8'h5b;
  localparam logic [7:0] CH_SS3     = 8'h4f;
  localparam logic [7:0] CH_TILDE   = 8'h7e;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_1       = 8'h31;
  localparam logic [7:0] CH_3       = 8'h33;
  localparam logic [7:0] CH_4       = 8'h34;
  localparam logic [7:0] CH_5       = 8'h35;
  localparam logic [7:0] CH_6       = 8'h36;
  localparam logic [7:0] CH_7       = 8'h37;
  localparam logic [7:0] CH_8       = 8'h38;
  localparam logic [7:0] CH_9       = 8'h39;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_LEAD  = 4'b0100,
    PH_DIGIT = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    key_class_t key_class;
    logic [7:0] key_byte;
    logic       quit;
    coord_t     cursor_col;
    coord_t     cursor_row;
  } result_t;

  function automatic key_class_t letter_key(input logic [7:0] b, input logic bracket);
    key_class_t k;
    k = KEY_PLAIN;
    if (b == CH_H) k = KEY_HOME;
    else if (b == CH_F) k = KEY_END;
    else if (bracket) begin
      if (b == CH_A) k = KEY_UP;
      else if (b == CH_B) k = KEY_DOWN;
      else if (b == CH_C) k = KEY_RIGHT;
      else if (b == CH_D) k = KEY_LEFT;
    end
    return k;
  endfunction

  function automatic key_class_t digit_key(input logic [7:0] d);
    key_class_t k;
    case (d)
      CH_1, CH_7: k = KEY_HOME;
      CH_4, CH_8: k = KEY_END;
      CH_3:       k = KEY_DEL;
      CH_5:       k = KEY_PGUP;
      CH_6:       k = KEY_PGDN;
      default:    k = KEY_PLAIN;
    endcase
    return k;
  endfunction

  function automatic coord_t last_index(input coord_t size);
    return (size == '0) ? '0 : size - coord_t'(1);
  endfunction

endpackage

// ===== sv/terminal_key_cursor_tracker.sv =====
// ----------------------------------------------------------------------------
// terminal_key_cursor_tracker
// Decodes terminal bytes and read timeouts into keys and tracks a cursor.
// ----------------------------------------------------------------------------
// input channel item_valid/item_stall carries one byte or a read timeout.
// output channel result_valid/result_stall carries a decoded key with the
// cursor column and row after it; each item gives zero or one result.
// escape prefixes are absorbed; a key appears when its sequence completes,
// a timeout inside a sequence or an unknown sequence gives a plain escape.
// result_valid rises in the cycle after acceptance; one item per cycle
// is accepted while results are taken, set by a single result register.
// item_stall rises only while a result is held and result_stall is high;
// a held result stays unchanged until taken.
// cfg_we writes screen_rows (index 0) or screen_cols (index 1).
// synchronous reset empties the result register, returns the decoder to
// idle, puts the cursor at 0,0 and loads 24 rows by 80 columns.
// ----------------------------------------------------------------------------
module terminal_key_cursor_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  tkct_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tkct_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tkct_pkg::SIZE_BITS-1:0]      cfg_data
);
  import tkct_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] held_digit, held_digit_next;
  coord_t     col_pos, col_pos_next;
  coord_t     row_pos, row_pos_next;
  coord_t     screen_rows, screen_cols;

  logic       accept;
  logic       emit;
  key_class_t cls;
  logic [7:0] kbyte;
  logic       is_digit;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;
  assign is_digit   = (item.rx_byte >= CH_0) && (item.rx_byte <= CH_9);

  always_comb begin
    phase_next      = phase;
    lead_byte_next  = lead_byte;
    held_digit_next = held_digit;
    emit            = 1'b0;
    cls             = KEY_PLAIN;
    kbyte           = CH_ESC;
    case (phase)
      PH_IDLE: begin
        if (!item.action) begin
          if (item.rx_byte == CH_ESC) begin
            phase_next = PH_ESC;
          end else begin
            emit  = 1'b1;
            kbyte = item.rx_byte;
          end
        end
      end
      PH_ESC: begin
        if (item.action) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
        end else begin
          lead_byte_next = item.rx_byte;
          phase_next     = PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (item.action) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
        end else if (lead_byte == CH_BRACKET && is_digit) begin
          held_digit_next = item.rx_byte;
          phase_next      = PH_DIGIT;
        end else begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          if (lead_byte == CH_BRACKET) cls = letter_key(item.rx_byte, 1'b1);
          else if (lead_byte == CH_SS3) cls = letter_key(item.rx_byte, 1'b0);
          kbyte = (cls == KEY_PLAIN) ? CH_ESC : 8'h00;
        end
      end
      PH_DIGIT: begin
        phase_next = PH_IDLE;
        emit       = 1'b1;
        if (!item.action && item.rx_byte == CH_TILDE) cls = digit_key(held_digit);
        kbyte = (cls == KEY_PLAIN) ? CH_ESC : 8'h00;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    case (cls)
      KEY_LEFT:  if (col_pos != '0) col_pos_next = col_pos - coord_t'(1);
      KEY_RIGHT: if (col_pos < screen_cols) col_pos_next = col_pos + coord_t'(1);
      KEY_UP:    if (row_pos != '0) row_pos_next = row_pos - coord_t'(1);
      KEY_DOWN:  if (row_pos < screen_rows) row_pos_next = row_pos + coord_t'(1);
      KEY_HOME:  col_pos_next = '0;
      KEY_END:   col_pos_next = last_index(screen_cols);
      KEY_PGUP:  row_pos_next = '0;
      KEY_PGDN:  row_pos_next = last_index(screen_rows);
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      col_pos      <= '0;
      row_pos      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        result_valid <= emit;
        if (emit) begin
          col_pos <= col_pos_next;
          row_pos <= row_pos_next;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lead_byte  <= lead_byte_next;
      held_digit <= held_digit_next;
    end
    if (accept && emit) begin
      result.key_class  <= cls;
      result.key_byte   <= kbyte;
      result.quit       <= (cls == KEY_PLAIN) && (kbyte == CH_CTRL_Q);
      result.cursor_col <= col_pos_next;
      result.cursor_row <= row_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= coord_t'(24);
      screen_cols <= coord_t'(80);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: screen_rows <= cfg_data;
        REG_COLS: screen_cols <= cfg_data;
        default:  ;
      endcase
    end
  end

`ifndef SYNTH
  a_quit_plain: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.quit |->
      result.key_class == KEY_PLAIN && result.key_byte == CH_CTRL_Q)
    else $error("quit flag on a non ctrl-q key");

  a_decoded_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.key_class != KEY_PLAIN |-> result.key_byte == 8'h00)
    else $error("decoded key carries a byte");

  a_idle_timeout: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && item.action |=>
      phase == PH_IDLE && result_valid == $past(result_valid && result_stall))
    else $error("timeout while idle changed state or produced a result");
`endif

endmodule
